FILE: design/ucfr_pkg.sv
// Shared types and constants for the UART command frame receiver.
package ucfr_pkg;

  // Longest frame held before it is dropped
  localparam int MAX_FRAME = 12;
  // Byte counter width: holds MAX_FRAME + 1
  localparam int CNT_W = $clog2(MAX_FRAME + 2);
  // Frame store depth
  localparam int STORE_DEPTH = 2 ** CNT_W;

  localparam logic [7:0] START_DELIM_RST = 8'h7f;
  // Frame layout
  localparam int HDR_BYTES = 4;   // start, command, access, length
  localparam int OVERHEAD   = 5;  // header plus checksum
  localparam int MAX_PAYLOAD = 8; // results per frame
  localparam int IDX_W = $clog2(MAX_PAYLOAD);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int FLEN_W = 4;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    ST_RX,
    ST_READ,
    ST_OUT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic rx_take;   // input word accepted this cycle
    logic rd_en;     // fetch payload byte at current index
    logic next_idx;  // step to next payload byte
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_good;  // current word closes a frame with a good checksum
    logic idx_last;    // current result is the last of the frame
  } dp_stat_t;

endpackage

FILE: design/ucfr_dp.sv
// Datapath: frame parsing counters, running checksum, payload store and result fields.
module ucfr_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic [7:0]                   rx_byte_i,
  input  ucfr_pkg::ctrl_cmd_t          cmd_i,
  output ucfr_pkg::dp_stat_t           stat_o,
  output logic [ucfr_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                         out_last_o
);
  import ucfr_pkg::*;

  logic [7:0]       delim_q;
  logic             in_frame_q, in_frame_d;
  logic [CNT_W-1:0] count_q, count_d, count_new;
  logic [7:0]       length_q;
  logic [7:0]       sum_q;
  logic [7:0]       cmd_q, acc_q;
  logic [CNT_W-1:0] flen_q;
  logic [IDX_W-1:0] idx_q;
  logic [7:0]       rdata_q;
  logic [7:0]       store_mem [STORE_DEPTH];

  logic [7:0]       len_eff;
  logic             frame_end, overflow, payload_none;
  logic             frame_good, idx_last;
  logic [CNT_W-1:0] rd_addr;

  // Start delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= START_DELIM_RST;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  // Frame end detection; the length byte is compared from the fourth byte on
  always_comb begin
    count_new = count_q + CNT_W'(1);
    len_eff   = (count_q == CNT_W'(HDR_BYTES - 1)) ? rx_byte_i : length_q;
    frame_end = in_frame_q && (count_new >= CNT_W'(HDR_BYTES))
                && ({{(8 - CNT_W){1'b0}}, count_new} == len_eff);
    overflow  = in_frame_q && !frame_end && (count_new > CNT_W'(MAX_FRAME));
    frame_good = cmd_i.rx_take && frame_end && (sum_q == rx_byte_i);
  end

  // Status to the controller
  assign stat_o = '{frame_good: frame_good, idx_last: idx_last};

  // Frame state and byte counter
  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    if (cmd_i.rx_take) begin
      if (in_frame_q) begin
        if (frame_end || overflow) begin
          in_frame_d = 1'b0;
          count_d    = '0;
        end else begin
          count_d = count_new;
        end
      end else if (rx_byte_i == delim_q) begin
        in_frame_d = 1'b1;
        count_d    = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

  // Header fields and running checksum of bytes after the start byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_take) begin
      if (!in_frame_q) begin
        sum_q <= '0;
      end else begin
        sum_q <= sum_q + rx_byte_i;
        if (count_q == CNT_W'(1)) cmd_q <= rx_byte_i;
        if (count_q == CNT_W'(2)) acc_q <= rx_byte_i;
        if (count_q == CNT_W'(3)) length_q <= rx_byte_i;
      end
    end
    if (frame_good) begin
      flen_q <= count_new;
    end
  end

  // Payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.rx_take && in_frame_q) begin
      store_mem[count_q] <= rx_byte_i;
    end
  end

  assign rd_addr = CNT_W'(HDR_BYTES) + CNT_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  // Result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (frame_good) begin
      idx_q <= '0;
    end else if (cmd_i.next_idx) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Result fields
  always_comb begin
    payload_none = flen_q <= CNT_W'(OVERHEAD);
    idx_last     = payload_none || (idx_q == IDX_W'(MAX_PAYLOAD - 1))
                   || ((CNT_W'(idx_q) + CNT_W'(OVERHEAD + 1)) == flen_q);
    out_last_o = idx_last;
    out_data_o = {!payload_none,
                  payload_none ? 8'h00 : rdata_q,
                  payload_none ? {IDX_W{1'b0}} : idx_q,
                  FLEN_W'(flen_q),
                  acc_q,
                  cmd_q};
  end

endmodule

FILE: design/ucfr_ctrl.sv
// Controller: switches between taking bytes and reading out a completed frame.
module ucfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ucfr_pkg::dp_stat_t  stat_i,
  output ucfr_pkg::ctrl_cmd_t cmd_o
);
  import ucfr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RX;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_RX: begin
        in_ready_o    = 1'b1;
        cmd_o.rx_take = in_valid_i;
        if (stat_i.frame_good) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.idx_last) begin
            state_d = ST_RX;
          end else begin
            cmd_o.next_idx = 1'b1;
            state_d        = ST_READ;
          end
        end
      end
      default: state_d = ST_RX;
    endcase
  end

endmodule

FILE: design/uart_command_frame_receiver.sv
// Top level: receives UART bytes, checks command frames and streams their payload.
// After a good checksum word, the read state fetches the first result for output.
// Throughput: one received word per cycle while collecting; each result then takes
// a payload store read and an output state held until taken; no input is taken meanwhile.
// Reset (rst_ni low, asynchronous): idle, byte count cleared, start delimiter 0x7f;
// the payload store is not cleared.
module uart_command_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] command, [15:8] access_kind, [19:16] frame_length,
  // [22:20] payload_index, [30:23] payload_byte, [31] payload_valid
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import ucfr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ucfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ucfr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rx_byte_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule
